// ===== rtl/ddct_pkg.sv =====
// Package for the dual down-counter timer core.
// Holds opcodes, register word codes, control bit positions and mask helpers.
// No dependencies.
package ddct_pkg;

  localparam int NUM_TIMERS = 2;

  localparam int DATA_W = 32;
  localparam int CTRL_W = 8;
  localparam int PRE_W  = 8;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    W_LOAD   = 3'd0,
    W_VALUE  = 3'd1,
    W_CTRL   = 3'd2,
    W_INTCLR = 3'd3,
    W_RIS    = 3'd4,
    W_MIS    = 3'd5,
    W_BGLOAD = 3'd6,
    W_NONE   = 3'd7
  } word_t;

  localparam int CTL_ENABLE   = 7;
  localparam int CTL_PERIODIC = 6;
  localparam int CTL_IE       = 5;
  localparam int CTL_RSVD     = 4;
  localparam int CTL_SIZE32   = 1;
  localparam int CTL_ONESHOT  = 0;

  localparam logic [CTRL_W-1:0] CTL_STORED = 8'hEF;
  localparam logic [CTRL_W-1:0] CTL_RESET  = 8'h20;

  typedef logic [DATA_W-1:0] word_data_t;
  typedef logic [CTRL_W-1:0] ctrl_t;
  typedef logic [PRE_W-1:0]  pre_t;

  function automatic word_data_t size_mask(input ctrl_t ctrl);
    return ctrl[CTL_SIZE32] ? 32'hFFFF_FFFF : 32'h0000_FFFF;
  endfunction

  function automatic pre_t divider_mask(input ctrl_t ctrl);
    pre_t dm;
    case (ctrl[3:2])
      2'd0:    dm = 8'd0;
      2'd1:    dm = 8'd15;
      default: dm = 8'd255;
    endcase
    return dm;
  endfunction

endpackage

// ===== rtl/dual_down_counter_timer_core.sv =====
// Top level of the dual down-counter timer core: register window, counters
// and a two-entry result buffer. Depends on ddct_pkg.
//
//   channel | ports                                   | direction
//   in      | in_valid in_ready in_op in_word_addr     | beat in
//           | in_write_data                            |
//   out     | out_valid out_ready out_read_data        | beat out
//           | out_irq_zero out_irq_one                 |
//
// One beat per cycle while in_ready is high: each accepted beat updates
// timer state and writes its result into the output buffer in the same
// cycle. A two-entry buffer lets a new beat in while one result waits.
// in_ready drops only when both entries are full. Reset (rst_n,
// synchronous) restores all timer registers and empties the buffer.
module dual_down_counter_timer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_op,
  input  logic [3:0]                 in_word_addr,
  input  logic [ddct_pkg::DATA_W-1:0] in_write_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ddct_pkg::DATA_W-1:0] out_read_data,
  output logic                       out_irq_zero,
  output logic                       out_irq_one
);
  import ddct_pkg::*;

  word_data_t load_r  [NUM_TIMERS];
  word_data_t load_nxt[NUM_TIMERS];
  word_data_t cnt_r   [NUM_TIMERS];
  word_data_t cnt_nxt [NUM_TIMERS];
  ctrl_t      ctrl_r  [NUM_TIMERS];
  ctrl_t      ctrl_nxt[NUM_TIMERS];
  logic       raw_r   [NUM_TIMERS];
  logic       raw_nxt [NUM_TIMERS];
  pre_t       pre_r   [NUM_TIMERS];
  pre_t       pre_nxt [NUM_TIMERS];

  word_data_t cnt_m   [NUM_TIMERS];
  word_data_t sz_m    [NUM_TIMERS];
  pre_t       div_m   [NUM_TIMERS];

  word_data_t rd_nxt;
  logic [1:0] irq_nxt;

  logic       out_valid_r, skid_valid_r;
  word_data_t out_rd_r, skid_rd_r;
  logic [1:0] out_irq_r, skid_irq_r;

  logic  acc, pop;
  op_t   op;
  word_t wsel;

  assign op       = op_t'(in_op);
  assign wsel     = word_t'(in_word_addr[2:0]);
  assign in_ready = !skid_valid_r;
  assign acc      = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  always_comb begin
    rd_nxt  = '0;
    irq_nxt = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      load_nxt[t] = load_r[t];
      cnt_nxt[t]  = cnt_r[t];
      ctrl_nxt[t] = ctrl_r[t];
      raw_nxt[t]  = raw_r[t];
      pre_nxt[t]  = pre_r[t];
      sz_m[t]     = size_mask(ctrl_r[t]);
      div_m[t]    = divider_mask(ctrl_r[t]);
      cnt_m[t]    = cnt_r[t] & sz_m[t];

      if (acc && op == OP_READ && in_word_addr[3] == 1'(t)) begin
        case (wsel)
          W_LOAD:   rd_nxt = load_r[t];
          W_VALUE:  rd_nxt = cnt_m[t];
          W_CTRL:   rd_nxt = {24'd0, ctrl_r[t]};
          W_RIS:    rd_nxt = {31'd0, raw_r[t]};
          W_MIS:    rd_nxt = {31'd0, raw_r[t] & ctrl_r[t][CTL_IE]};
          W_BGLOAD: rd_nxt = load_r[t];
          default:  rd_nxt = '0;
        endcase
      end

      if (acc && op == OP_WRITE && in_word_addr[3] == 1'(t)) begin
        case (wsel)
          W_LOAD: begin
            load_nxt[t] = in_write_data;
            cnt_nxt[t]  = in_write_data;
          end
          W_CTRL:   ctrl_nxt[t] = in_write_data[CTRL_W-1:0] & CTL_STORED;
          W_INTCLR: raw_nxt[t]  = 1'b0;
          W_BGLOAD: load_nxt[t] = in_write_data;
          default: ;
        endcase
      end

      if (acc && op == OP_TICK && ctrl_r[t][CTL_ENABLE]) begin
        if ((pre_r[t] & div_m[t]) == div_m[t]) begin
          pre_nxt[t] = '0;
          if (cnt_m[t] == '0) begin
            if (ctrl_r[t][CTL_ONESHOT]) begin
              cnt_nxt[t] = '0;
            end else if (ctrl_r[t][CTL_PERIODIC]) begin
              cnt_nxt[t] = load_r[t] & sz_m[t];
              if ((load_r[t] & sz_m[t]) == '0) raw_nxt[t] = 1'b1;
            end else begin
              cnt_nxt[t] = sz_m[t];
            end
          end else begin
            cnt_nxt[t] = cnt_m[t] - 32'd1;
            if (cnt_m[t] == 32'd1) raw_nxt[t] = 1'b1;
          end
        end else begin
          pre_nxt[t] = pre_r[t] + 8'd1;
        end
      end

      irq_nxt[t] = ctrl_nxt[t][CTL_IE] & raw_nxt[t];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        load_r[t] <= '0;
        cnt_r[t]  <= '1;
        ctrl_r[t] <= CTL_RESET;
        raw_r[t]  <= 1'b0;
        pre_r[t]  <= '0;
      end
    end else begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        load_r[t] <= load_nxt[t];
        cnt_r[t]  <= cnt_nxt[t];
        ctrl_r[t] <= ctrl_nxt[t];
        raw_r[t]  <= raw_nxt[t];
        pre_r[t]  <= pre_nxt[t];
      end
    end
  end

  // two-entry result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_rd_r     <= skid_rd_r;
        out_irq_r    <= skid_irq_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= acc;
        if (acc) begin
          out_rd_r  <= rd_nxt;
          out_irq_r <= irq_nxt;
        end
      end
    end else if (acc) begin
      if (!out_valid_r) begin
        out_valid_r <= 1'b1;
        out_rd_r    <= rd_nxt;
        out_irq_r   <= irq_nxt;
      end else begin
        skid_valid_r <= 1'b1;
        skid_rd_r    <= rd_nxt;
        skid_irq_r   <= irq_nxt;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_rd_r;
  assign out_irq_zero  = out_irq_r[0];
  assign out_irq_one   = out_irq_r[1];

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without head entry");

  a_rsvd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r[0][CTL_RSVD] == 1'b0)
    else $error("reserved control bit set");

  a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_op == OP_TICK && !ctrl_r[0][CTL_ENABLE]) |=>
      ($stable(cnt_r[0]) && $stable(pre_r[0])))
    else $error("disabled timer moved on tick");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !skid_valid_r))
    else $error("result buffer not empty after reset");

  a_full_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !pop) |=> skid_valid_r)
    else $error("skid entry lost without drain");

endmodule
